[rtl/slru_pkg.sv]
// ----------------------------------------------------------------------------
// slru_pkg
// Shared constants, codes and types of the segmented LRU block cache.
// ----------------------------------------------------------------------------
package slru_pkg;

  // segment sizes and run limit
  localparam int unsigned P_ENTRIES = 64;
  localparam int unsigned Q_ENTRIES = 64;
  localparam int unsigned MAX_ENTRIES = (P_ENTRIES > Q_ENTRIES) ? P_ENTRIES : Q_ENTRIES;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned USED_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned RUN_W = 7;
  localparam int unsigned TAG_W = 64;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned BSL_W = 5;
  localparam logic [BSL_W-1:0] BSL_RESET = 5'd12;

  // block queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // where a block was found
  localparam logic [1:0] WHERE_MISS = 2'd0;
  localparam logic [1:0] WHERE_PROB = 2'd1;
  localparam logic [1:0] WHERE_PROT = 2'd2;

  // request kinds
  localparam logic OP_READ = 1'b0;
  localparam logic OP_DEMOTE = 1'b1;

  // segment select
  localparam logic SEG_PROT = 1'b0;
  localparam logic SEG_PROB = 1'b1;

  // one block of a request
  typedef struct packed {
    logic [31:0] blk;
    logic [31:0] obj;
    logic [3:0]  origin;
    logic        op;
    logic        last;
  } slru_item_t;

  // queue write side: push from the front and the queue's full flag
  typedef struct packed {
    logic push;
    logic full;
  } slru_qwr_t;

endpackage

[rtl/slru_ram.sv]
// ----------------------------------------------------------------------------
// slru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slru_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/slru_fifo.sv]
// ----------------------------------------------------------------------------
// slru_fifo
// Short block queue between the request front and the cache back.
// ----------------------------------------------------------------------------
module slru_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  slru_pkg::slru_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output slru_pkg::slru_item_t pop_item,
  output logic                 empty
);

  slru_pkg::slru_item_t mem_r [slru_pkg::FIFO_DEPTH];
  logic [slru_pkg::FIFO_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [slru_pkg::FIFO_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [slru_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full = (cnt_r == slru_pkg::FIFO_CNT_W'(slru_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_item = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

[rtl/slru_front.sv]
// ----------------------------------------------------------------------------
// slru_front
// Accepts requests and splits each run into per-block items for the queue.
// ----------------------------------------------------------------------------
module slru_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [3:0]           in_origin,
  input  logic [31:0]          in_object_id,
  input  logic [31:0]          in_first_block,
  input  logic [6:0]           in_block_count,
  output slru_pkg::slru_qwr_t  qwr,
  input  logic                 q_full,
  output slru_pkg::slru_item_t q_item
);

  logic                          busy_r, busy_nxt;
  logic [31:0]                   blk_r, blk_nxt;
  logic [slru_pkg::RUN_W-1:0]    remain_r, remain_nxt;
  logic                          op_r, op_nxt;
  logic [3:0]                    origin_r, origin_nxt;
  logic [31:0]                   obj_r, obj_nxt;
  logic [slru_pkg::RUN_W-1:0]    count_sat;
  logic                          emit;

  assign busy = busy_r;
  assign emit = busy_r && !q_full;
  assign count_sat = (in_block_count > slru_pkg::RUN_W'(slru_pkg::MAX_RUN)) ?
                     slru_pkg::RUN_W'(slru_pkg::MAX_RUN) : in_block_count;

  // item toward the queue
  always_comb begin
    q_item.blk = blk_r;
    q_item.obj = obj_r;
    q_item.origin = origin_r;
    q_item.op = op_r;
    q_item.last = (remain_r == slru_pkg::RUN_W'(1));
    qwr.push = emit;
    qwr.full = q_full;
  end

  // request capture and block walk
  always_comb begin
    busy_nxt = busy_r;
    blk_nxt = blk_r;
    remain_nxt = remain_r;
    op_nxt = op_r;
    origin_nxt = origin_r;
    obj_nxt = obj_r;
    if (start && !busy_r) begin
      blk_nxt = in_first_block;
      remain_nxt = count_sat;
      op_nxt = in_op;
      origin_nxt = in_origin;
      obj_nxt = in_object_id;
      busy_nxt = (count_sat != '0);
    end else if (emit) begin
      blk_nxt = blk_r + 32'd1;
      remain_nxt = remain_r - 1'b1;
      busy_nxt = (remain_r != slru_pkg::RUN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    remain_r <= remain_nxt;
    op_r <= op_nxt;
    origin_r <= origin_nxt;
    obj_r <= obj_nxt;
  end

endmodule

[rtl/slru_back.sv]
// ----------------------------------------------------------------------------
// slru_back
// Per-block tag search and recency update of the two segments.
// Each segment is a tag RAM kept in recency order: entry 0 is the MRU,
// entry used-1 the LRU.
// ----------------------------------------------------------------------------
module slru_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  slru_pkg::slru_item_t              q_item,
  output logic                              q_pop,
  input  logic [slru_pkg::BSL_W-1:0]        block_size_log2,
  output logic                              out_valid,
  output logic [31:0]                       out_block_index,
  output logic [1:0]                        out_where_found,
  output logic                              out_fetch_valid,
  output logic [3:0]                        out_fetch_origin,
  output logic [31:0]                       out_fetch_object,
  output logic [slru_pkg::ADDR_W-1:0]       out_fetch_address,
  output logic                              out_last
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PRD   = 15'b000000000000010,
    S_PCMP  = 15'b000000000000100,
    S_QRD   = 15'b000000000001000,
    S_QCMP  = 15'b000000000010000,
    S_UCHK  = 15'b000000000100000,
    S_URD   = 15'b000000001000000,
    S_UWR   = 15'b000000010000000,
    S_LRD   = 15'b000000100000000,
    S_LCAP  = 15'b000001000000000,
    S_PUSH  = 15'b000010000000000,
    S_DRD   = 15'b000100000000000,
    S_DWR   = 15'b001000000000000,
    S_FRONT = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  // what follows the write at the MRU end
  typedef enum logic [3:0] {
    PH_TOUCH  = 4'b0001,
    PH_DEMOTE = 4'b0010,
    PH_PPUSH  = 4'b0100,
    PH_MISS   = 4'b1000
  } phase_t;

  localparam int unsigned IW = slru_pkg::IDX_W;
  localparam int unsigned UW = slru_pkg::USED_W;
  localparam int unsigned TW = slru_pkg::TAG_W;

  state_t                state_r, state_nxt;
  phase_t                ph_r, ph_nxt;
  slru_pkg::slru_item_t  cur_r, cur_nxt;
  logic [1:0]            where_r, where_nxt;
  logic [UW-1:0]         idx_r, idx_nxt;
  logic                  sel_r, sel_nxt;
  logic [TW-1:0]         val_r, val_nxt;
  logic [UW-1:0]         pused_r, pused_nxt;
  logic [UW-1:0]         qused_r, qused_nxt;

  logic                  p_we, q_we;
  logic [IW-1:0]         p_waddr, q_waddr, p_raddr, q_raddr;
  logic [TW-1:0]         p_wdata, q_wdata, p_rdata, q_rdata;
  logic [TW-1:0]         tag;
  logic [UW-1:0]         sel_used;
  logic [TW-1:0]         sel_rdata;
  logic                  fetch;
  logic [slru_pkg::ADDR_W-1:0] addr_ext;

  assign tag = {cur_r.obj, cur_r.blk};
  assign sel_used = (sel_r == slru_pkg::SEG_PROT) ? pused_r : qused_r;
  assign sel_rdata = (sel_r == slru_pkg::SEG_PROT) ? p_rdata : q_rdata;

  slru_ram #(.WIDTH(slru_pkg::TAG_W), .DEPTH(slru_pkg::P_ENTRIES)) u_prot_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  slru_ram #(.WIDTH(slru_pkg::TAG_W), .DEPTH(slru_pkg::Q_ENTRIES)) u_prob_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    cur_nxt = cur_r;
    where_nxt = where_r;
    idx_nxt = idx_r;
    sel_nxt = sel_r;
    val_nxt = val_r;
    pused_nxt = pused_r;
    qused_nxt = qused_r;
    q_pop = 1'b0;
    p_we = 1'b0;
    q_we = 1'b0;
    p_waddr = '0;
    q_waddr = '0;
    p_wdata = val_r;
    q_wdata = val_r;
    p_raddr = '0;
    q_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          cur_nxt = q_item;
          idx_nxt = '0;
          state_nxt = S_PRD;
        end
      end
      // protected search: each entry is read, then compared
      S_PRD: begin
        p_raddr = idx_r[IW-1:0];
        if (idx_r >= pused_r) begin
          idx_nxt = '0;
          state_nxt = S_QRD;
        end else begin
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (p_rdata == tag) begin
          where_nxt = slru_pkg::WHERE_PROT;
          sel_nxt = slru_pkg::SEG_PROT;
          val_nxt = tag;
          ph_nxt = PH_TOUCH;
          state_nxt = (idx_r == '0) ? S_FRONT : S_DRD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      // probationary search; running off the end is a miss
      S_QRD: begin
        q_raddr = idx_r[IW-1:0];
        if (idx_r >= qused_r) begin
          where_nxt = slru_pkg::WHERE_MISS;
          if (qused_r == UW'(slru_pkg::Q_ENTRIES)) begin
            qused_nxt = qused_r - 1'b1;
          end
          sel_nxt = slru_pkg::SEG_PROB;
          val_nxt = tag;
          ph_nxt = PH_MISS;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_QCMP;
        end
      end
      S_QCMP: begin
        if (q_rdata == tag) begin
          where_nxt = slru_pkg::WHERE_PROB;
          state_nxt = S_UCHK;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_QRD;
        end
      end
      // close the gap left by the promoted block
      S_UCHK: begin
        if (UW'(idx_r + 1'b1) < qused_r) begin
          state_nxt = S_URD;
        end else begin
          qused_nxt = qused_r - 1'b1;
          if (pused_r == UW'(slru_pkg::P_ENTRIES)) begin
            state_nxt = S_LRD;
          end else begin
            sel_nxt = slru_pkg::SEG_PROT;
            val_nxt = tag;
            ph_nxt = PH_PPUSH;
            state_nxt = S_PUSH;
          end
        end
      end
      S_URD: begin
        q_raddr = IW'(idx_r + 1'b1);
        state_nxt = S_UWR;
      end
      S_UWR: begin
        q_we = 1'b1;
        q_waddr = idx_r[IW-1:0];
        q_wdata = q_rdata;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_UCHK;
      end
      // protected full: its LRU drops to the probationary MRU end
      S_LRD: begin
        p_raddr = IW'(pused_r - 1'b1);
        state_nxt = S_LCAP;
      end
      S_LCAP: begin
        val_nxt = p_rdata;
        pused_nxt = pused_r - 1'b1;
        sel_nxt = slru_pkg::SEG_PROB;
        ph_nxt = PH_DEMOTE;
        state_nxt = S_PUSH;
      end
      // insert at MRU end: shift entries 0..used-1 down by one
      S_PUSH: begin
        idx_nxt = sel_used;
        state_nxt = (sel_used == '0) ? S_FRONT : S_DRD;
      end
      S_DRD: begin
        p_raddr = IW'(idx_r - 1'b1);
        q_raddr = IW'(idx_r - 1'b1);
        state_nxt = S_DWR;
      end
      S_DWR: begin
        p_we = (sel_r == slru_pkg::SEG_PROT);
        q_we = (sel_r == slru_pkg::SEG_PROB);
        p_waddr = idx_r[IW-1:0];
        q_waddr = idx_r[IW-1:0];
        p_wdata = sel_rdata;
        q_wdata = sel_rdata;
        idx_nxt = idx_r - 1'b1;
        state_nxt = (idx_r == UW'(1)) ? S_FRONT : S_DRD;
      end
      S_FRONT: begin
        p_we = (sel_r == slru_pkg::SEG_PROT);
        q_we = (sel_r == slru_pkg::SEG_PROB);
        if (ph_r != PH_TOUCH) begin
          if (sel_r == slru_pkg::SEG_PROT) begin
            pused_nxt = pused_r + 1'b1;
          end else begin
            qused_nxt = qused_r + 1'b1;
          end
        end
        case (ph_r)
          PH_DEMOTE: begin
            sel_nxt = slru_pkg::SEG_PROT;
            val_nxt = tag;
            ph_nxt = PH_PPUSH;
            state_nxt = S_PUSH;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r <= PH_TOUCH;
      pused_r <= '0;
      qused_r <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
      pused_r <= pused_nxt;
      qused_r <= qused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    where_r <= where_nxt;
    idx_r <= idx_nxt;
    sel_r <= sel_nxt;
    val_r <= val_nxt;
  end

  // result strobe and fields
  assign fetch = (where_r == slru_pkg::WHERE_MISS) && (cur_r.op == slru_pkg::OP_READ);
  assign addr_ext = slru_pkg::ADDR_W'(cur_r.blk) << block_size_log2;
  assign out_valid = (state_r == S_OUT);
  assign out_block_index = cur_r.blk;
  assign out_where_found = where_r;
  assign out_fetch_valid = fetch;
  assign out_fetch_origin = fetch ? cur_r.origin : 4'd0;
  assign out_fetch_object = fetch ? cur_r.obj : 32'd0;
  assign out_fetch_address = fetch ? addr_ext : '0;
  assign out_last = cur_r.last;

endmodule

[rtl/segmented_lru_block_cache.sv]
// ----------------------------------------------------------------------------
// segmented_lru_block_cache
// Two-segment LRU block cache: one result per block of each request.
// ----------------------------------------------------------------------------
// Usage:
// - requests enter on in_* when start is high and busy is low; busy stays
//   high while the front still splits the run into blocks for its queue
// - a run of 0 blocks gives no result; runs over 64 blocks are cut to 64
// - each block gives one result on out_*, marked by a one-cycle out_valid;
//   results cannot be held off and come in request and block order
// - cfg_valid/cfg_ready writes block_size_log2 (reset 12); cfg_ready is
//   always high; write it only while no block is in flight
// - per block: a protected scan that reads, then compares each resident
//   entry, then a probationary scan, then recency shifts that read, then
//   write each moved entry (check, read, then write per entry when closing
//   the gap of a promoted block) in the single-port-pair tag RAMs, plus
//   control states; the work is greatest when both 64-entry segments are
//   full and a probationary hit demotes the protected LRU
// - reset empties both segments at once (occupancy counts only); the tag
//   RAMs need no clearing pass
// ----------------------------------------------------------------------------
module segmented_lru_block_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [3:0]  in_origin,
  input  logic [31:0] in_object_id,
  input  logic [31:0] in_first_block,
  input  logic [6:0]  in_block_count,
  output logic        out_valid,
  output logic [31:0] out_block_index,
  output logic [1:0]  out_where_found,
  output logic        out_fetch_valid,
  output logic [3:0]  out_fetch_origin,
  output logic [31:0] out_fetch_object,
  output logic [47:0] out_fetch_address,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_block_size_log2
);

  slru_pkg::slru_qwr_t  qwr;
  slru_pkg::slru_item_t f_item, b_item;
  logic q_full, q_empty, q_pop;
  logic [slru_pkg::BSL_W-1:0] bsl_r, bsl_nxt;

  // configuration register
  assign cfg_ready = 1'b1;
  assign bsl_nxt = (cfg_valid && cfg_ready) ? cfg_block_size_log2 : bsl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r <= slru_pkg::BSL_RESET;
    end else begin
      bsl_r <= bsl_nxt;
    end
  end

  slru_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_origin      (in_origin),
    .in_object_id   (in_object_id),
    .in_first_block (in_first_block),
    .in_block_count (in_block_count),
    .qwr            (qwr),
    .q_full         (q_full),
    .q_item         (f_item)
  );

  slru_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (qwr.push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (b_item),
    .empty     (q_empty)
  );

  slru_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (b_item),
    .q_pop             (q_pop),
    .block_size_log2   (bsl_r),
    .out_valid         (out_valid),
    .out_block_index   (out_block_index),
    .out_where_found   (out_where_found),
    .out_fetch_valid   (out_fetch_valid),
    .out_fetch_origin  (out_fetch_origin),
    .out_fetch_object  (out_fetch_object),
    .out_fetch_address (out_fetch_address),
    .out_last          (out_last)
  );

endmodule

[rtl/slru_checker.sv]
// ----------------------------------------------------------------------------
// slru_checker
// Port-level checks of the segmented LRU block cache.
// ----------------------------------------------------------------------------
module slru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [1:0]  out_where_found,
  input logic        out_fetch_valid,
  input logic [3:0]  out_fetch_origin,
  input logic [31:0] out_fetch_object,
  input logic [47:0] out_fetch_address
);

  // where code is one of the three meanings
  a_where_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_where_found == slru_pkg::WHERE_MISS ||
                   out_where_found == slru_pkg::WHERE_PROB ||
                   out_where_found == slru_pkg::WHERE_PROT))
    else $error("bad where code");

  // a fetch only on a miss
  a_fetch_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fetch_valid) |-> (out_where_found == slru_pkg::WHERE_MISS))
    else $error("fetch on a hit");

  // fetch fields are zero without a fetch
  a_fetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fetch_valid) |->
      (out_fetch_origin == '0 && out_fetch_object == '0 && out_fetch_address == '0))
    else $error("fetch fields set without fetch");

  // results never come on two adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

endmodule

bind segmented_lru_block_cache slru_checker u_slru_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_where_found   (out_where_found),
  .out_fetch_valid   (out_fetch_valid),
  .out_fetch_origin  (out_fetch_origin),
  .out_fetch_object  (out_fetch_object),
  .out_fetch_address (out_fetch_address)
);
